// ----- sv/ctm_pkg.sv -----
// ----------------------------------------------------------------------------
// ctm_pkg
// Shared widths, codes and controller/datapath interface types for the
// cosine template matcher.
// ----------------------------------------------------------------------------
package ctm_pkg;

  localparam int VAL_W      = 16;
  localparam int SUM_W      = 48;
  localparam int HALF_W     = 24;
  localparam int PROD_W     = 96;
  localparam int SCORE_W    = 17;
  localparam int IDX_W      = 6;
  localparam int QUOT_W     = 32;
  localparam int ROOT_W     = 16;
  localparam int SQREM_W    = 18;
  localparam int CNT_W      = 5;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [CNT_W-1:0] MUL_LAST  = 5'd7;
  localparam logic [CNT_W-1:0] DIV_LAST  = 5'd31;
  localparam logic [CNT_W-1:0] SQRT_LAST = 5'd15;

  localparam logic [SCORE_W-1:0] SCORE_ONE    = 17'h10000;
  localparam logic [SCORE_W-1:0] THRESH_RESET = 17'd32768;

  // register index taken from paddr[2]
  localparam logic REG_MATCH_THRESHOLD = 1'b0;

  // product select code, mul_sel[2]
  localparam logic PROD_NORM  = 1'b0;
  localparam logic PROD_INNER = 1'b1;

  typedef struct packed {
    logic       take;
    logic       prod_clear;
    logic       mul_issue;
    logic [2:0] mul_sel;
    logic       div_init;
    logic       div_step;
    logic       sqrt_step;
    logic       score_zero;
    logic       score_one;
    logic       score_root;
    logic       finish;
  } ctm_cmd_t;

  typedef struct packed {
    logic eov_taken;
    logic zero_norm;
    logic saturate;
    logic out_free;
  } ctm_status_t;

endpackage

// ----- sv/ctm_ctrl.sv -----
// ----------------------------------------------------------------------------
// ctm_ctrl
// Sequencer: element streaming, product build, division and root steps,
// result hand-off.
// ----------------------------------------------------------------------------
module ctm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctm_pkg::ctm_status_t status,
  output ctm_pkg::ctm_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_SETTLE,
    ST_MUL,
    ST_MUL_TAIL,
    ST_CMP,
    ST_DIV,
    ST_SQRT,
    ST_ROOT,
    ST_FINISH
  } state_t;

  state_t                    state_r, state_nxt;
  logic [ctm_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_ACCUM: begin
        cmd.take = 1'b1;
        if (status.eov_taken) begin
          state_nxt = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        cmd.prod_clear = 1'b1;
        cnt_nxt        = '0;
        state_nxt      = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_issue = 1'b1;
        cmd.mul_sel   = cnt_r[2:0];
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == ctm_pkg::MUL_LAST) begin
          state_nxt = ST_MUL_TAIL;
        end
      end
      ST_MUL_TAIL: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cnt_nxt = '0;
        if (status.zero_norm) begin
          cmd.score_zero = 1'b1;
          state_nxt      = ST_FINISH;
        end else if (status.saturate) begin
          cmd.score_one = 1'b1;
          state_nxt     = ST_FINISH;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == ctm_pkg::DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == ctm_pkg::SQRT_LAST) begin
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd.score_root = 1'b1;
        state_nxt      = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_ACCUM;
        end
      end
      default: begin
        state_nxt = ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACCUM;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_eov_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && status.eov_taken) |=> (state_r == ST_SETTLE && !cmd.take))
    else $error("input not stopped after closing element");

endmodule

// ----- sv/ctm_dp.sv -----
// ----------------------------------------------------------------------------
// ctm_dp
// Datapath: element products and sums, 24x24 partial-product unit for the
// norm and inner products, restoring divider, digit-by-digit root, best
// tracking and the result register.
// ----------------------------------------------------------------------------
module ctm_dp #(
  parameter int MAX_REFS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ctm_pkg::ctm_cmd_t                cmd,
  output ctm_pkg::ctm_status_t             status,
  input  logic [ctm_pkg::SCORE_W-1:0]      match_threshold,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ctm_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tlast,
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ctm_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tlast,
  output logic                             out_tuser
);

  localparam int REF_W = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
  localparam logic [REF_W-1:0] REF_LAST = REF_W'(MAX_REFS - 1);

  localparam int VW = ctm_pkg::VAL_W;
  localparam int SW = ctm_pkg::SUM_W;
  localparam int HW = ctm_pkg::HALF_W;
  localparam int PW = ctm_pkg::PROD_W;
  localparam int QW = ctm_pkg::QUOT_W;
  localparam int RW = ctm_pkg::ROOT_W;
  localparam int MW = ctm_pkg::SQREM_W;
  localparam int CW = ctm_pkg::SCORE_W;
  localparam int XW = ctm_pkg::IDX_W;

  logic            accept;
  logic [VW-1:0]   ref_val, query_val;

  logic            v1_r, eov1_r, eos1_r;
  logic [2*VW-1:0] prod_rq_r, prod_rr_r, prod_qq_r;
  logic [SW-1:0]   inner_r, rsq_r, qsq_r;
  logic            set_end_r;

  logic [SW-1:0]   x_word, y_word;
  logic [HW-1:0]   x_half, y_half;
  logic [2*HW-1:0] mult, mult_r;
  logic [2:0]      tag_sel_r;
  logic            tag_valid_r;
  logic [PW-1:0]   mult_ext, addend;
  logic [PW-1:0]   prod_p_r, prod_s_r;

  logic [PW:0]     rem_sh, rem_diff;
  logic            div_ge;
  logic [PW-1:0]   rem_r;
  logic [QW-1:0]   quot_r;

  logic [MW-1:0]   sq_cand, sq_trial;
  logic            sq_ge;
  logic [MW-1:0]   sq_rem_r;
  logic [RW-1:0]   root_r;

  logic [CW-1:0]   score_r;
  logic [CW-1:0]   best_r, best_new;
  logic [REF_W-1:0] best_idx_r, best_idx_new, ref_cnt_r;
  logic            best_gt;
  logic [REF_W+XW-1:0] ref_ext, best_ext;

  logic            out_valid_r;
  logic [CW-1:0]   o_score_r, o_best_r;
  logic [XW-1:0]   o_ref_r, o_best_idx_r;
  logic            o_matched_r, o_done_r;

  // element intake
  assign in_tready = cmd.take;
  assign accept    = in_tvalid && cmd.take;
  assign ref_val   = in_tdata[VW-1:0];
  assign query_val = in_tdata[2*VW-1:VW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      eov1_r <= 1'b0;
      eos1_r <= 1'b0;
    end else begin
      v1_r   <= accept;
      eov1_r <= accept && in_tlast;
      eos1_r <= accept && in_tlast && in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_rq_r <= ref_val * query_val;
      prod_rr_r <= ref_val * ref_val;
      prod_qq_r <= query_val * query_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r   <= '0;
      rsq_r     <= '0;
      qsq_r     <= '0;
      set_end_r <= 1'b0;
    end else if (cmd.finish) begin
      inner_r <= '0;
      rsq_r   <= '0;
      qsq_r   <= '0;
    end else if (v1_r) begin
      inner_r <= inner_r + {{(SW-2*VW){1'b0}}, prod_rq_r};
      rsq_r   <= rsq_r + {{(SW-2*VW){1'b0}}, prod_rr_r};
      qsq_r   <= qsq_r + {{(SW-2*VW){1'b0}}, prod_qq_r};
      if (eov1_r) begin
        set_end_r <= eos1_r;
      end
    end
  end

  // partial products: sel[2] picks the product, sel[1:0] the halves
  always_comb begin
    x_word = (cmd.mul_sel[2] == ctm_pkg::PROD_INNER) ? inner_r : rsq_r;
    y_word = (cmd.mul_sel[2] == ctm_pkg::PROD_INNER) ? inner_r : qsq_r;
    x_half = cmd.mul_sel[1] ? x_word[SW-1:HW] : x_word[HW-1:0];
    y_half = cmd.mul_sel[0] ? y_word[SW-1:HW] : y_word[HW-1:0];
    mult   = x_half * y_half;
  end

  always_comb begin
    mult_ext = {{(PW-2*HW){1'b0}}, mult_r};
    case (tag_sel_r[1:0])
      2'b00:   addend = mult_ext;
      2'b11:   addend = mult_ext << (2*HW);
      default: addend = mult_ext << HW;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_valid_r <= 1'b0;
    end else begin
      tag_valid_r <= cmd.mul_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_issue) begin
      mult_r    <= mult;
      tag_sel_r <= cmd.mul_sel;
    end
    if (cmd.prod_clear) begin
      prod_p_r <= '0;
      prod_s_r <= '0;
    end else if (tag_valid_r) begin
      if (tag_sel_r[2] == ctm_pkg::PROD_INNER) begin
        prod_s_r <= prod_s_r + addend;
      end else begin
        prod_p_r <= prod_p_r + addend;
      end
    end
  end

  // restoring divider and root
  always_comb begin
    rem_sh   = {rem_r, 1'b0};
    rem_diff = rem_sh - {1'b0, prod_p_r};
    div_ge   = rem_sh >= {1'b0, prod_p_r};
    sq_cand  = {sq_rem_r[MW-3:0], quot_r[QW-1:QW-2]};
    sq_trial = {root_r, 2'b01};
    sq_ge    = sq_cand >= sq_trial;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r    <= prod_s_r;
      quot_r   <= '0;
      sq_rem_r <= '0;
      root_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= div_ge ? rem_diff[PW-1:0] : rem_sh[PW-1:0];
      quot_r <= {quot_r[QW-2:0], div_ge};
    end else if (cmd.sqrt_step) begin
      sq_rem_r <= sq_ge ? (sq_cand - sq_trial) : sq_cand;
      root_r   <= {root_r[RW-2:0], sq_ge};
      quot_r   <= {quot_r[QW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.score_zero) begin
      score_r <= '0;
    end else if (cmd.score_one) begin
      score_r <= ctm_pkg::SCORE_ONE;
    end else if (cmd.score_root) begin
      score_r <= {{(CW-RW){1'b0}}, root_r};
    end
  end

  // best tracking and result
  always_comb begin
    best_gt      = score_r > best_r;
    best_new     = best_gt ? score_r : best_r;
    best_idx_new = best_gt ? ref_cnt_r : best_idx_r;
    ref_ext      = {{XW{1'b0}}, ref_cnt_r};
    best_ext     = {{XW{1'b0}}, best_idx_new};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r     <= '0;
      best_idx_r <= '0;
      ref_cnt_r  <= '0;
    end else if (cmd.finish) begin
      if (set_end_r) begin
        best_r     <= '0;
        best_idx_r <= '0;
        ref_cnt_r  <= '0;
      end else begin
        best_r     <= best_new;
        best_idx_r <= best_idx_new;
        ref_cnt_r  <= (ref_cnt_r == REF_LAST) ? '0 : ref_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      o_score_r    <= score_r;
      o_ref_r      <= ref_ext[XW-1:0];
      o_best_idx_r <= best_ext[XW-1:0];
      o_best_r     <= best_new;
      o_matched_r  <= set_end_r && (best_new > match_threshold);
      o_done_r     <= set_end_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(ctm_pkg::OUT_DATA_W-2*CW-2*XW){1'b0}},
                       o_best_r, o_best_idx_r, o_ref_r, o_score_r};
  assign out_tlast  = o_done_r;
  assign out_tuser  = o_matched_r;

  assign status.eov_taken = accept && in_tlast;
  assign status.zero_norm = (rsq_r == '0) || (qsq_r == '0);
  assign status.saturate  = prod_s_r >= prod_p_r;
  assign status.out_free  = !out_valid_r || out_tready;

  a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> status.out_free)
    else $error("result loaded over a pending transaction");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.div_step) |-> (rem_r < prod_p_r))
    else $error("division remainder out of range");

  a_closing_item_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && eov1_r) |-> !cmd.take)
    else $error("input taken while vector sums settle");

endmodule

// ----- sv/cosine_template_match_unit.sv -----
// ----------------------------------------------------------------------------
// cosine_template_match_unit
// Cosine-similarity nearest-template matcher with APB threshold register.
// ----------------------------------------------------------------------------
// Throughput: one element pair per cycle within a vector.
// Vector end: input is held off after the closing transaction until the result
//   is valid; a zero norm or a saturated score skips the division and root. The
//   32-step divider and 16-step root follow an 8-step 24x24 product unit.
// Reset (sync, rst_n low): sums, best score/index and reference counter clear,
//   match_threshold returns to 32768, no result pending.
module cosine_template_match_unit #(
  parameter int MAX_REFS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ctm_pkg::IN_DATA_W-1:0]   in_tdata,   // ref_value, query_value
  input  logic                            in_tlast,   // end_of_vector
  input  logic                            in_tuser,   // end_of_set
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ctm_pkg::OUT_DATA_W-1:0]  out_tdata,  // score, ref_number,
                                                      // best_number, best_value
  output logic                            out_tlast,  // set_done
  output logic                            out_tuser,  // matched
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [ctm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [ctm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [ctm_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  ctm_pkg::ctm_cmd_t             cmd;
  ctm_pkg::ctm_status_t          status;
  logic [ctm_pkg::SCORE_W-1:0]   thresh_r;
  logic                          cfg_wr;
  logic                          reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= ctm_pkg::THRESH_RESET;
    end else if (cfg_wr && reg_idx == ctm_pkg::REG_MATCH_THRESHOLD) begin
      thresh_r <= cfg_pwdata[ctm_pkg::SCORE_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      ctm_pkg::REG_MATCH_THRESHOLD:
        cfg_prdata = {{(ctm_pkg::CFG_DATA_W-ctm_pkg::SCORE_W){1'b0}}, thresh_r};
      default:
        cfg_prdata = '0;
    endcase
  end

  ctm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  ctm_dp #(
    .MAX_REFS (MAX_REFS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .match_threshold (thresh_r),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .out_tuser       (out_tuser)
  );

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for cosine_template_match_unit. Drives element pairs
// over the input stream with random gaps and random result back-pressure,
// predicts every cosine score, best reference and match flag, and checks
// each result transaction in order. The threshold register is written and
// read back over APB between phases.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DRAIN_CYCLES = 100;
  localparam logic [ctm_pkg::CFG_ADDR_W-1:0] THRESHOLD_ADDR =
    {ctm_pkg::REG_MATCH_THRESHOLD, 2'b00};

  typedef struct {
    logic [ctm_pkg::SCORE_W-1:0] score;
    logic [ctm_pkg::IDX_W-1:0]   ref_number;
    logic [ctm_pkg::IDX_W-1:0]   best_number;
    logic [ctm_pkg::SCORE_W-1:0] best_value;
    logic                        matched;
    logic                        set_done;
  } match_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [ctm_pkg::IN_DATA_W-1:0]  in_tdata;   // ref_value, query_value
  logic                           in_tlast;   // end_of_vector
  logic                           in_tuser;   // end_of_set
  logic                           out_tvalid;
  logic                           out_tready;
  logic [ctm_pkg::OUT_DATA_W-1:0] out_tdata;  // score, ref_number, best_number, best_value
  logic                           out_tlast;  // set_done
  logic                           out_tuser;  // matched
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [ctm_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [ctm_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [ctm_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  // predicted block state
  logic [ctm_pkg::SUM_W-1:0]   inner_acc;
  logic [ctm_pkg::SUM_W-1:0]   ref_sq_acc;
  logic [ctm_pkg::SUM_W-1:0]   query_sq_acc;
  logic [ctm_pkg::SCORE_W-1:0] best_score_q;
  logic [ctm_pkg::IDX_W-1:0]   best_idx;
  logic [ctm_pkg::IDX_W-1:0]   ref_count;
  logic [ctm_pkg::SCORE_W-1:0] threshold;

  match_result_t pending_scores[$];
  int errors = 0;
  int cfg_errors = 0;
  int pairs_sent = 0;
  int ready_hold = 0;
  bit quiet = 1'b0;

  cosine_template_match_unit dut (.*);

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int gap_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // largest s <= 1.0 with s^2 * |a|^2 * |b|^2 <= (a.b)^2, in Q1.16
  function automatic logic [ctm_pkg::SCORE_W-1:0] cosine_score(
      input logic [ctm_pkg::SUM_W-1:0] inner,
      input logic [ctm_pkg::SUM_W-1:0] ref_norm,
      input logic [ctm_pkg::SUM_W-1:0] query_norm);
    logic [159:0] lhs, rhs, norm_prod, m;
    int unsigned lo, hi, mid;
    if (ref_norm == '0 || query_norm == '0) return '0;
    lo = 0;
    hi = 65536;
    rhs = 160'(inner);
    rhs = (rhs * rhs) << 32;
    norm_prod = 160'(ref_norm);
    norm_prod = norm_prod * 160'(query_norm);
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      m = 160'(mid);
      lhs = m * m * norm_prod;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return ctm_pkg::SCORE_W'(lo);
  endfunction

  task automatic predict_pair(input logic [ctm_pkg::VAL_W-1:0] r,
                              input logic [ctm_pkg::VAL_W-1:0] q,
                              input logic eov, input logic eos);
    match_result_t res;
    logic [ctm_pkg::SCORE_W-1:0] s;
    inner_acc    = inner_acc + ctm_pkg::SUM_W'(r) * ctm_pkg::SUM_W'(q);
    ref_sq_acc   = ref_sq_acc + ctm_pkg::SUM_W'(r) * ctm_pkg::SUM_W'(r);
    query_sq_acc = query_sq_acc + ctm_pkg::SUM_W'(q) * ctm_pkg::SUM_W'(q);
    if (eov) begin
      s = cosine_score(inner_acc, ref_sq_acc, query_sq_acc);
      res.score = s;
      res.ref_number = ref_count;
      if (s > best_score_q) begin
        best_score_q = s;
        best_idx = ref_count;
      end
      res.best_number = best_idx;
      res.best_value = best_score_q;
      res.set_done = eos;
      res.matched = eos && (best_score_q > threshold);
      pending_scores.insert(pending_scores.size(), res);
      inner_acc = '0;
      ref_sq_acc = '0;
      query_sq_acc = '0;
      ref_count = ref_count + 1'b1;
      if (eos) begin
        best_score_q = '0;
        best_idx = '0;
        ref_count = '0;
      end
    end
  endtask

  task automatic send_pair(input logic [ctm_pkg::VAL_W-1:0] r,
                           input logic [ctm_pkg::VAL_W-1:0] q,
                           input logic eov, input logic eos);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {q, r};
    in_tlast  <= eov;
    in_tuser  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pair(r, q, eov, eos);
    pairs_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic read_threshold();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= THRESHOLD_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== ctm_pkg::CFG_DATA_W'(threshold)) begin
      $display("%0t: match_threshold expected %0d actual %0d", $time, threshold, cfg_prdata);
      cfg_errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic write_threshold(input logic [ctm_pkg::SCORE_W-1:0] value);
    drain();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= THRESHOLD_ADDR;
    cfg_pwdata  <= ctm_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    threshold = value;
    read_threshold();
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    match_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_scores.size() == 0) begin
        $display("%0t: result expected none actual score %0d", $time, out_tdata[16:0]);
        errors++;
      end else begin
        want = pending_scores.pop_front();
        check_field("score", 32'(want.score), 32'(out_tdata[16:0]));
        check_field("ref_number", 32'(want.ref_number), 32'(out_tdata[22:17]));
        check_field("best_number", 32'(want.best_number), 32'(out_tdata[28:23]));
        check_field("best_value", 32'(want.best_value), 32'(out_tdata[45:29]));
        check_field("set_done", 32'(want.set_done), 32'(out_tlast));
        check_field("matched", 32'(want.matched), 32'(out_tuser));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) ready_hold <= gap_cycles();
    end
  end

  // reset value of the threshold register, then corner vectors under it
  task automatic test_extremes();
    read_threshold();
    send_pair(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    send_pair(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);  // saturates at 1.0
    send_pair(16'hFFFF, 16'h0000, 1'b1, 1'b0);  // zero query norm
    send_pair(16'h0000, 16'h0000, 1'b1, 1'b0);  // both norms zero
    send_pair(16'hFFFF, 16'h0000, 1'b0, 1'b0);
    send_pair(16'h0000, 16'hFFFF, 1'b1, 1'b0);  // orthogonal
    send_pair(16'h0001, 16'hFFFF, 1'b1, 1'b1);  // ties the best
  endtask

  task automatic test_stray_set_end();
    send_pair(16'd100, 16'd200, 1'b0, 1'b1);
    send_pair(16'd300, 16'd50, 1'b0, 1'b1);
    send_pair(16'd7, 16'd9, 1'b1, 1'b0);
    send_pair(16'd40000, 16'd1, 1'b1, 1'b1);
  endtask

  task automatic test_tie();
    write_threshold(17'd65536);
    send_pair(16'd3, 16'd4, 1'b0, 1'b0);
    send_pair(16'd4, 16'd3, 1'b1, 1'b0);
    send_pair(16'd3, 16'd4, 1'b0, 1'b0);
    send_pair(16'd4, 16'd3, 1'b1, 1'b0);
    send_pair(16'd1, 16'd1, 1'b1, 1'b0);
    send_pair(16'd0, 16'd5, 1'b1, 1'b1);
  endtask

  task automatic test_threshold_edges();
    write_threshold(17'd65535);
    send_pair(16'd9, 16'd9, 1'b1, 1'b1);
    write_threshold(17'd0);
    send_pair(16'd0, 16'd0, 1'b1, 1'b1);
    send_pair(16'hFFFF, 16'd1, 1'b1, 1'b1);
    write_threshold(17'd62914);
    send_pair(16'd3, 16'd4, 1'b0, 1'b0);
    send_pair(16'd4, 16'd3, 1'b1, 1'b1);
  endtask

  // more references than the counter holds
  task automatic test_long_set();
    write_threshold(17'd32768);
    for (int k = 0; k < 70; k++)
      send_pair(ctm_pkg::VAL_W'($urandom), ctm_pkg::VAL_W'($urandom), 1'b1, k == 69);
  endtask

  task automatic make_pair(input int style, output logic [ctm_pkg::VAL_W-1:0] r,
                           output logic [ctm_pkg::VAL_W-1:0] q);
    r = ctm_pkg::VAL_W'($urandom);
    case (style)
      0: q = ctm_pkg::VAL_W'($urandom);
      1: q = r ^ ctm_pkg::VAL_W'($urandom_range(0, 255));
      2: q = r >> $urandom_range(0, 3);
      3: begin
        r = 16'h0000;
        q = ctm_pkg::VAL_W'($urandom);
      end
      default: begin
        r = ($urandom_range(0, 1) == 0) ? 16'hFFFF : ctm_pkg::VAL_W'($urandom_range(0, 3));
        q = ($urandom_range(0, 1) == 0) ? 16'hFFFF : ctm_pkg::VAL_W'($urandom_range(0, 3));
      end
    endcase
  endtask

  task automatic send_set();
    int refs, len, style;
    logic [ctm_pkg::VAL_W-1:0] r, q;
    logic eov, eos;
    quiet = ($urandom_range(0, 4) == 0);
    refs = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
    for (int k = 0; k < refs; k++) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
      style = $urandom_range(0, 4);
      for (int e = 0; e < len; e++) begin
        make_pair(style, r, q);
        eov = (e == len - 1);
        eos = eov ? (k == refs - 1) : ($urandom_range(0, 9) == 0);
        send_pair(r, q, eov, eos);
      end
    end
  endtask

  task automatic test_random();
    int goal;
    logic [ctm_pkg::SCORE_W-1:0] thr;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: thr = ctm_pkg::SCORE_W'($urandom_range(55000, 65535));
        1: thr = 17'd0;
        2: thr = 17'd65536;
        3: thr = 17'd65535;
        default: thr = ctm_pkg::SCORE_W'($urandom_range(0, 65536));
      endcase
      write_threshold(thr);
      goal = pairs_sent + 180;
      while (pairs_sent < goal) send_set();
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    in_tuser    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    inner_acc    = '0;
    ref_sq_acc   = '0;
    query_sq_acc = '0;
    best_score_q = '0;
    best_idx     = '0;
    ref_count    = '0;
    threshold    = ctm_pkg::THRESH_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_stray_set_end();
    test_tie();
    test_threshold_edges();
    test_long_set();
    test_random();
    drain();
    if (errors == 0 && cfg_errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
